FILE: design/assert_macros.svh
// assertion macros shared by the sharpening filter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// clocked check, masked while reset is held
`define SCF_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("%m: assertion failed");

// clocked check that also runs across reset
`define SCF_ASSERT_NORST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");

`else

`define SCF_ASSERT(lbl, clk, rstn, prop)
`define SCF_ASSERT_NORST(lbl, clk, prop)

`endif

`endif

FILE: design/scf_pkg.sv
// shared types, widths and constants of the cross sharpening filter
package scf_pkg;

    localparam int PIX_W      = 8;
    localparam int NCH        = 3;
    localparam int ROW_W      = 16;
    localparam int COL_W      = 11;
    localparam int IMG_W_W    = 12;
    localparam int IMG_H_W    = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    // defaults for the top level parameters
    localparam int MAX_WIDTH_DEF = 2048;
    localparam int CHANNELS_DEF  = 3;

    // register reset values
    localparam logic [IMG_W_W-1:0] IMG_W_RST = IMG_W_W'(640);
    localparam logic [IMG_H_W-1:0] IMG_H_RST = IMG_H_W'(480);

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    // input word
    typedef struct packed {
        logic [PIX_W-1:0] in_chan0;
        logic [PIX_W-1:0] in_chan1;
        logic [PIX_W-1:0] in_chan2;
    } in_item_t;

    // result word
    typedef struct packed {
        logic [ROW_W-1:0] out_row;
        logic [COL_W-1:0] out_col;
        logic [PIX_W-1:0] out_chan0;
        logic [PIX_W-1:0] out_chan1;
        logic [PIX_W-1:0] out_chan2;
    } out_item_t;

endpackage

FILE: design/scf_line_mem.sv
// two-row line memory with one read and one write port and write-to-read bypass
module scf_line_mem import scf_pkg::*; #(
    parameter int DEPTH = MAX_WIDTH_DEF,
    parameter int AW    = 11,
    parameter int DW    = 2 * NCH * PIX_W
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem_array [DEPTH];
    logic [DW-1:0] rd_data_reg;
    logic [DW-1:0] fwd_data_reg;
    logic          fwd_hit_reg;

    // storage and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_array[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg  <= mem_array[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    // bypass flag when a read hits the entry written in the same cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_hit_reg <= 1'b0;
        end else if (rd_en) begin
            fwd_hit_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = fwd_hit_reg ? fwd_data_reg : rd_data_reg;

endmodule

FILE: design/sharpen_cross_3x3_filter_core.sv
// top level of the 3x3 cross sharpening filter for three-channel pixel streams
//
//  channel | ports                          | dir | carries
//  --------+--------------------------------+-----+------------------------------------
//  input   | s_valid s_ready s_data         | in  | one pixel word in raster order
//  result  | m_valid m_ready m_data         | out | row, column and sharpened channels
//  config  | cfg_valid cfg_ready cfg_index  | in  | register index and write data
//          | cfg_data                       |     |
//
//  one word per cycle sustained while m_ready holds high; a result is built from the middle
//  stage and the registered read of the line memory and is held in the output register.
//  the line memory takes one read and one write each cycle; a read of the entry being
//  written (unit image width) is served from a bypass register.
//  reset is synchronous and clears the position counters, valid flags and configuration
//  registers; the line memory is not cleared, so no clearing pass is needed.
//  a stall on m_ready holds the output word and the middle stage; s_ready drops only
//  while the middle stage is full and cannot move on.
`include "assert_macros.svh"

module sharpen_cross_3x3_filter_core import scf_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int CHANNELS  = CHANNELS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = (AW + 1 > IMG_W_W) ? AW + 1 : IMG_W_W;
    localparam int NL = (CHANNELS < NCH) ? CHANNELS : NCH;
    localparam int LW = NL * PIX_W;
    localparam int MW = 2 * LW;
    localparam logic [WW-1:0] MAXW_C = WW'(MAX_WIDTH);

    typedef logic [NL-1:0][PIX_W-1:0] lanes_t;

    // configuration and position state
    logic [IMG_W_W-1:0] width_reg;
    logic [IMG_H_W-1:0] height_reg;
    logic [AW-1:0]      col_count_reg, col_count_next;
    logic [ROW_W-1:0]   row_count_reg, row_count_next;

    // middle stage
    logic               s1_valid_reg;
    logic [AW-1:0]      s1_col_reg;
    logic [ROW_W-1:0]   s1_row_reg;
    logic [COL_W-1:0]   s1_ocol_reg;
    logic               s1_border_reg;
    lanes_t             s1_px_reg;

    // window registers: down, up, center, left
    lanes_t             dn_reg, up_reg, ctr_reg, lf_reg;

    // output stage
    logic               m_valid_reg;
    out_item_t          m_data_reg, m_data_next;

    // stage 0 datapath
    logic [WW-1:0]      w_eff, width_ext, col_ext, ocol_w, c_inc;
    logic [IMG_H_W-1:0] h_eff;
    logic [AW-1:0]      c0;
    logic [ROW_W-1:0]   r0, orow;
    logic [ROW_W:0]     r_inc;
    logic               border0;
    logic [NCH-1:0][PIX_W-1:0] in_lanes;

    // handshake and memory
    logic               s_acc, s1_adv;
    logic [MW-1:0]      mem_rd_data, mem_wr_data;
    lanes_t             rt_lanes, upn_lanes;
    logic [NCH-1:0][PIX_W-1:0] res_lanes;

    function automatic logic [PIX_W-1:0] sharpen_px(
        input logic [PIX_W-1:0] ctr,
        input logic [PIX_W-1:0] up,
        input logic [PIX_W-1:0] dn,
        input logic [PIX_W-1:0] lf,
        input logic [PIX_W-1:0] rt
    );
        logic [11:0] v;
        v = {2'b00, ctr, 2'b00} + {4'h0, ctr} - {4'h0, up} - {4'h0, dn}
            - {4'h0, lf} - {4'h0, rt};
        if (v[11]) begin
            sharpen_px = '0;
        end else if (v[10:8] != 3'b000) begin
            sharpen_px = '1;
        end else begin
            sharpen_px = v[7:0];
        end
    endfunction

    // handshakes
    assign s1_adv    = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !s1_valid_reg || s1_adv;
    assign s_acc     = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // effective frame size and position of the incoming word
    always_comb begin
        width_ext = WW'(width_reg);
        if (width_reg == '0) begin
            w_eff = WW'(1);
        end else if (width_ext > MAXW_C) begin
            w_eff = MAXW_C;
        end else begin
            w_eff = width_ext;
        end
        h_eff   = (height_reg == '0) ? IMG_H_W'(1) : height_reg;
        col_ext = WW'(col_count_reg);
        c0      = (col_ext >= w_eff) ? '0 : col_count_reg;
        r0      = (row_count_reg >= h_eff) ? '0 : row_count_reg;
        ocol_w  = (c0 == '0) ? w_eff - WW'(1) : WW'(c0) - WW'(1);
        orow    = (r0 == '0) ? h_eff - ROW_W'(1) : r0 - ROW_W'(1);
        border0 = (orow == '0) || (orow == h_eff - ROW_W'(1))
               || (ocol_w == '0) || (ocol_w == w_eff - WW'(1));
        c_inc   = WW'(c0) + WW'(1);
        r_inc   = {1'b0, r0} + (ROW_W + 1)'(1);
        if (c_inc >= w_eff) begin
            col_count_next = '0;
            row_count_next = (r_inc >= {1'b0, h_eff}) ? '0 : r_inc[ROW_W-1:0];
        end else begin
            col_count_next = c_inc[AW-1:0];
            row_count_next = r0;
        end
    end

    assign in_lanes = {s_data.in_chan2, s_data.in_chan1, s_data.in_chan0};

    // line memory holds the previous row in the upper half, the one before in the lower
    assign rt_lanes    = mem_rd_data[MW-1 -: LW];
    assign upn_lanes   = mem_rd_data[LW-1:0];
    assign mem_wr_data = {s1_px_reg, rt_lanes};

    scf_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW),
        .DW    (MW)
    ) u_line_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data (mem_wr_data),
        .rd_en   (s_acc),
        .rd_addr (c0),
        .rd_data (mem_rd_data)
    );

    // kernel on the window, zero on the border and for unused channels
    always_comb begin
        res_lanes = '0;
        for (int k = 0; k < NL; k++) begin
            if (!s1_border_reg) begin
                res_lanes[k] = sharpen_px(ctr_reg[k], up_reg[k], dn_reg[k], lf_reg[k],
                                          rt_lanes[k]);
            end
        end
        m_data_next.out_row   = s1_row_reg;
        m_data_next.out_col   = s1_ocol_reg;
        m_data_next.out_chan0 = res_lanes[0];
        m_data_next.out_chan1 = res_lanes[1];
        m_data_next.out_chan2 = res_lanes[2];
    end

    // control: configuration, counters and valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg     <= IMG_W_RST;
            height_reg    <= IMG_H_RST;
            col_count_reg <= '0;
            row_count_reg <= '0;
            s1_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_IMAGE_WIDTH:  width_reg  <= cfg_data[IMG_W_W-1:0];
                    REG_IMAGE_HEIGHT: height_reg <= cfg_data[IMG_H_W-1:0];
                    default: ;
                endcase
            end
            if (s_acc) begin
                col_count_reg <= col_count_next;
                row_count_reg <= row_count_next;
                s1_valid_reg  <= 1'b1;
            end else if (s1_adv) begin
                s1_valid_reg  <= 1'b0;
            end
            if (s1_adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload: stage registers, window shift and output word
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            s1_col_reg    <= c0;
            s1_row_reg    <= orow;
            s1_ocol_reg   <= ocol_w[COL_W-1:0];
            s1_border_reg <= border0;
            s1_px_reg     <= in_lanes[NL-1:0];
        end
        if (s1_adv) begin
            lf_reg     <= ctr_reg;
            ctr_reg    <= rt_lanes;
            dn_reg     <= s1_px_reg;
            up_reg     <= upn_lanes;
            m_data_reg <= m_data_next;
        end
    end

    `SCF_ASSERT(a_full_stage_blocks_input, aclk, aresetn, (s1_valid_reg && !s1_adv) |-> !s_ready)
    `SCF_ASSERT(a_out_stall_holds_stage, aclk, aresetn, (m_valid_reg && !m_ready) |-> !s1_adv)
    `SCF_ASSERT(a_accept_fills_stage, aclk, aresetn, s_acc |=> s1_valid_reg)
    `SCF_ASSERT(a_same_entry_only_unit_width, aclk, aresetn, (s1_adv && s_acc && (s1_col_reg == c0)) |-> (w_eff == WW'(1)))
    `SCF_ASSERT(a_top_row_is_zero, aclk, aresetn, (m_valid_reg && (m_data_reg.out_row == '0)) |-> ((m_data_reg.out_chan0 == '0) && (m_data_reg.out_chan1 == '0) && (m_data_reg.out_chan2 == '0)))
    `SCF_ASSERT_NORST(a_reset_empties_pipe, aclk, !aresetn |=> (!m_valid_reg && !s1_valid_reg))

endmodule
